FILE: rtl/smpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the sorted max-priority queue
// Operation and status codes, field widths, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TOP  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    rd_start;
    logic    shift;
    logic    place;
    logic    dec_occ;
    logic    out_load;
    logic    out_head;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic idx_zero;
    logic greater;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/sorted_max_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue: bounded max-priority queue of signed values
// Input channel in_valid/in_stall carries operation (push, pop, top) and
// value; output channel out_valid/out_stall returns one item per input
// item: head_value, status and entry_count after the operation.
// An item is taken only when the block is idle. Pop and top go from
// acceptance through decode and memory read to the result register.
// A push shifts every stored entry larger than the value up by one
// slot: the insertion scan moves one entry per cycle through the
// single write port of the entry memory. Full, empty and no-op cases
// load the result straight from decode, with no memory read. The next
// item is taken the cycle after the result is loaded. A finished
// result waits in the output register while out_stall is high; the
// block keeps working and holds only when a second result is ready.
// Reset empties the queue at once; no clearing pass is needed since
// entries above the occupancy are never read.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smpq_pkg::OP_W-1:0]           operation,
  input  logic signed [smpq_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smpq_pkg::DATA_W-1:0]  head_value,
  output logic [smpq_pkg::STATUS_W-1:0]       status,
  output logic [smpq_pkg::COUNT_W-1:0]        entry_count
);
  import smpq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  smpq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  smpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head_value  (head_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

FILE: rtl/smpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_datapath: entry store, scan index, occupancy and result register
// Entries are held in ascending order, largest at occupancy - 1, so the
// head is one read away and a push shifts larger entries up one per cycle.
// ----------------------------------------------------------------------------
module smpq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smpq_pkg::cmd_t                cmd,
  output smpq_pkg::stat_t               st,
  input  logic [smpq_pkg::OP_W-1:0]     operation,
  input  logic signed [smpq_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [smpq_pkg::DATA_W-1:0] head_value,
  output logic [smpq_pkg::STATUS_W-1:0] status,
  output logic [smpq_pkg::COUNT_W-1:0]  entry_count
);
  import smpq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] val_q;
  op_t                      op_q;
  logic [CW-1:0]            occupancy;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            occ_m1;
  logic [CW-1:0]            idx_m2;
  logic [CW-1:0]            occ_after;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic                     wr_en;

  assign occ_m1  = occupancy - CW'(1);
  assign idx_m2  = idx - CW'(2);
  assign rd_en   = cmd.rd_start | cmd.shift;
  assign rd_addr = cmd.rd_start ? occ_m1[AW-1:0] : idx_m2[AW-1:0];
  assign wr_en   = cmd.shift | cmd.place;
  assign wr_addr = idx[AW-1:0];
  assign wr_data = cmd.shift ? rdata : val_q;

  always_comb begin
    priority if (cmd.place) begin
      occ_after = occupancy + CW'(1);
    end else if (cmd.dec_occ) begin
      occ_after = occupancy - CW'(1);
    end else begin
      occ_after = occupancy;
    end
  end

  assign st.op       = op_q;
  assign st.empty    = (occupancy == '0);
  assign st.full     = (occupancy == CW'(QUEUE_DEPTH));
  assign st.idx_zero = (idx == '0);
  assign st.greater  = (rdata > val_q);
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(operation);
      val_q <= value;
    end
    if (cmd.rd_start) begin
      idx <= occupancy;
    end else if (cmd.shift) begin
      idx <= idx - CW'(1);
    end
    if (cmd.out_load) begin
      head_value  <= cmd.out_head ? rdata : '0;
      status      <= cmd.out_status;
      entry_count <= COUNT_W'(occ_after);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occ_after;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");
  a_place_room: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !st.full)
    else $error("insert into a full store");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec_occ |-> !st.empty)
    else $error("removal from an empty store");
  a_shift_index: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> !st.idx_zero)
    else $error("shift below the bottom entry");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result register overwritten while held");
`endif

endmodule

FILE: rtl/smpq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_controller: sequencing of push, pop and top operations
// Takes one item, decodes it against the store status, runs the push scan
// or the head read, and loads the result register when it is free.
// ----------------------------------------------------------------------------
module smpq_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  smpq_pkg::stat_t st,
  output smpq_pkg::cmd_t  cmd
);
  import smpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_PUSH = 4'b0100,
    S_HEAD = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.op)
          OP_PUSH: begin
            if (!st.full) begin
              cmd.rd_start = 1'b1;
              state_next   = S_PUSH;
            end else if (st.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_FULL;
              state_next     = S_IDLE;
            end
          end
          OP_POP, OP_TOP: begin
            if (!st.empty) begin
              cmd.rd_start = 1'b1;
              state_next   = S_HEAD;
            end else if (st.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_EMPTY;
              state_next     = S_IDLE;
            end
          end
          default: begin
            if (st.out_free) begin
              cmd.out_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      S_PUSH: begin
        priority if (!st.idx_zero && st.greater) begin
          cmd.shift = 1'b1;
        end else if (st.out_free) begin
          cmd.place    = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_HEAD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_head = 1'b1;
          cmd.dec_occ  = (st.op == OP_POP);
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_EXEC))
    else $error("item taken without decode");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.capture)
    else $error("item taken while busy");
  a_place_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> (state == S_IDLE))
    else $error("push did not finish after insert");
`endif

endmodule

FILE: tb/sv/sorted_max_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_test: self-checking bench of the max-priority queue
// Drives push, pop, top and no-op items through the valid/stall input channel
// and compares every result against a behavioral sorted-list queue held in a
// scoreboard. A short directed pass covers the empty, full and extreme-value
// cases; random phases then swing the queue between empty and full while the
// sender bursts and the receiver stalls on independent patterns.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_test;

  import smpq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    logic signed [DATA_W-1:0] head;
    status_t                  st;
    logic [COUNT_W-1:0]       count;
  } queue_result_t;

  class priority_queue_scoreboard;
    logic signed [DATA_W-1:0] entries[DEPTH];
    int                       occupancy;
    queue_result_t            expected_results[$];
    int errors, n_push, n_pop, n_top, n_nop, full_hits, empty_hits, peak;

    function queue_result_t predict_operation(op_t op, logic signed [DATA_W-1:0] val);
      queue_result_t r;
      int            pos;
      int            i;
      r.head = '0;
      r.st   = ST_OK;
      case (op)
        OP_PUSH: begin
          n_push++;
          if (occupancy >= DEPTH) begin
            r.st = ST_FULL;
            full_hits++;
          end else begin
            pos = 0;
            while (pos < occupancy && entries[pos] > val) pos++;
            for (i = occupancy; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            occupancy++;
            if (occupancy > peak) peak = occupancy;
          end
        end
        OP_POP, OP_TOP: begin
          if (op == OP_POP) n_pop++;
          else n_top++;
          if (occupancy == 0) begin
            r.st = ST_EMPTY;
            empty_hits++;
          end else begin
            r.head = entries[0];
            if (op == OP_POP) begin
              for (i = 1; i < occupancy; i++) entries[i-1] = entries[i];
              occupancy--;
            end
          end
        end
        default: n_nop++;
      endcase
      r.count = COUNT_W'(occupancy);
      return r;
    endfunction

    function void note_operation(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
      expected_results.push_back(predict_operation(op_t'(op), val));
    endfunction

    function void check_result(logic signed [DATA_W-1:0] head, logic [STATUS_W-1:0] st,
                               logic [COUNT_W-1:0] count);
      queue_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no pending item: head_value %0d status %0d entry_count %0d",
               head, st, count);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (head !== e.head) begin
        $error("head_value: expected %0d, actual %0d", e.head, head);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        errors++;
      end
      if (count !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            operation;
  logic signed [DATA_W-1:0]   value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DATA_W-1:0]   head_value;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         entry_count;

  priority_queue_scoreboard sb;
  int cycles = 0;

  sorted_max_priority_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head_value  (head_value),
    .status      (status),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_operation(operation, value);
      if (out_valid && !out_stall) sb.check_result(head_value, status, entry_count);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[sorted_max_priority_queue] ERROR");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    in_valid  = 1'b1;
    operation = op;
    value     = val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  = 1'b0;
      operation = $urandom_range(0, 3);
      value     = $urandom;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4:    return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall pattern: free-running, random, periodic and long holds
  initial begin
    int mode;
    int span;
    int k;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      case (mode)
        0: repeat (span) begin
          @(negedge clk);
          out_stall = 1'b0;
        end
        1: repeat (span) begin
          @(negedge clk);
          out_stall = ($urandom_range(0, 99) < 40);
        end
        2: for (k = 0; k < span; k++) begin
          @(negedge clk);
          out_stall = (k % 5) < 2;
        end
        default: repeat ($urandom_range(1, 4)) begin
          repeat ($urandom_range(5, 40)) begin
            @(negedge clk);
            out_stall = 1'b1;
          end
          repeat ($urandom_range(1, 6)) begin
            @(negedge clk);
            out_stall = 1'b0;
          end
        end
      endcase
    end
  end

  initial begin
    int  n;
    int  seg_left;
    int  push_pct;
    int  burst_left;
    int  roll;
    op_t op;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_NOP;
    value      = '0;
    seg_left   = 0;
    push_pct   = 50;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_item(OP_POP, 32'sh7fffffff);
    send_item(OP_TOP, 32'sh80000000);
    send_item(OP_NOP, -32'sd1);
    send_item(OP_PUSH, 32'sh80000000);
    send_item(OP_PUSH, 32'sh7fffffff);
    send_item(OP_PUSH, -32'sd1);
    send_item(OP_PUSH, 32'sd0);
    send_item(OP_PUSH, 32'sh7fffffff);
    send_item(OP_TOP, 32'sd0);
    send_item(OP_POP, 32'sd0);
    for (n = 0; n < 12; n++) send_item(OP_PUSH, pick_value());
    send_item(OP_PUSH, 32'sh7fffffff);
    send_item(OP_NOP, 32'sh55555555);
    send_item(OP_TOP, 32'shaaaaaaaa);
    idle_cycles(3);

    // biased segments drive the queue toward full, toward empty, or hold it mid-way
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (roll < 4) op = OP_NOP;
      else if (roll < 4 + push_pct * 96 / 100) op = OP_PUSH;
      else op = ($urandom_range(0, 2) == 0) ? OP_TOP : OP_POP;
      send_item(op, pick_value());
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    idle_cycles(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d push, %0d pop, %0d top, %0d no-op items, peak occupancy %0d",
             sb.n_push, sb.n_pop, sb.n_top, sb.n_nop, sb.peak);
    $display("pushes refused as full: %0d, pops/tops refused as empty: %0d",
             sb.full_hits, sb.empty_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sorted_max_priority_queue] OK");
    end else begin
      $display("[sorted_max_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/smpq_pkg.sv
rtl/smpq_datapath.sv
rtl/smpq_controller.sv
rtl/sorted_max_priority_queue.sv
tb/sv/sorted_max_priority_queue_test.sv
